@@ rtl/core/ipv4_flow_key_extractor_assert.svh @@
// ----------------------------------------------------------------------------
// ipv4 flow key extractor assertion macros
// concurrent checks sampled on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef IPV4_FLOW_KEY_EXTRACTOR_ASSERT_SVH
`define IPV4_FLOW_KEY_EXTRACTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// expression holds at every edge
`define IPV4FK_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the following cycle
`define IPV4FK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IPV4FK_ASSERT_ALWAYS(label, expr, msg)
`define IPV4FK_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/core/ipv4fk_pkg.sv @@
// ----------------------------------------------------------------------------
// ipv4fk_pkg
// shared types and constants of the ipv4 flow key extractor
// ----------------------------------------------------------------------------
package ipv4fk_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 2048;

    // link type register codes
    localparam logic [1:0] LT_ETH = 2'd0;
    localparam logic [1:0] LT_PPP = 2'd1;
    localparam logic [1:0] LT_RAW = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOT_IP = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;

    localparam int ETH_SKIP    = 14;
    localparam int PPP_SKIP    = 5;
    localparam int RAW_SKIP    = 0;
    localparam int ETH_TAG_POS = 12;
    localparam int PPP_TAG_POS = 3;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] PPP_PROTO_IPV4 = 16'h0021;

    localparam int IP_MIN_HDR  = 20;
    localparam int TCP_MIN_HDR = 20;
    localparam int UDP_MIN_HDR = 8;

    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [3:0] IP_VERSION_4 = 4'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } result_t;

    // header fields captured by one framing lane
    typedef struct packed {
        logic [7:0]  ver_ihl;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] link_tag;
    } lane_key_t;

endpackage

@@ rtl/core/ipv4fk_lane.sv @@
// ----------------------------------------------------------------------------
// ipv4fk_lane
// latches the ip header fields of one framing as the frame bytes go by
// ----------------------------------------------------------------------------
module ipv4fk_lane
    import ipv4fk_pkg::*;
#(
    parameter int CW      = 11,
    parameter int SKIP    = ETH_SKIP,
    parameter int TAG_POS = ETH_TAG_POS
)
(
    input  logic            clk,
    input  logic            cap_en,
    input  logic [CW-1:0]   pos,
    input  logic [7:0]      data_byte,
    output lane_key_t       key
);

    lane_key_t     key_reg;
    lane_key_t     key_next;
    logic [5:0]    ihl_cur;
    logic [CW:0]   port_off;
    logic          port_hit;

    always_comb
    begin
        key_next = key_reg;
        // ihl comes from the current byte while that byte is the version/ihl byte
        ihl_cur  = (pos == CW'(SKIP)) ? {data_byte[3:0], 2'b00}
                                       : {key_reg.ver_ihl[3:0], 2'b00};
        port_off = {1'b0, pos} - (CW+1)'(SKIP) - (CW+1)'(ihl_cur);
        port_hit = !port_off[CW] && (port_off < (CW+1)'(4));
        if (cap_en)
        begin
            if (pos == CW'(SKIP))
                key_next.ver_ihl = data_byte;
            if (pos == CW'(SKIP + 9))
                key_next.protocol = data_byte;
            for (int k = 0; k < 4; k++)
            begin
                if (pos == CW'(SKIP + 12 + k))
                    key_next.src_addr[31 - 8*k -: 8] = data_byte;
                if (pos == CW'(SKIP + 16 + k))
                    key_next.dst_addr[31 - 8*k -: 8] = data_byte;
            end
            if (pos == CW'(TAG_POS))
                key_next.link_tag[15:8] = data_byte;
            if (pos == CW'(TAG_POS + 1))
                key_next.link_tag[7:0] = data_byte;
            if (port_hit)
            begin
                case (port_off[1:0])
                    2'd0:    key_next.src_port[15:8] = data_byte;
                    2'd1:    key_next.src_port[7:0]  = data_byte;
                    2'd2:    key_next.dst_port[15:8] = data_byte;
                    default: key_next.dst_port[7:0]  = data_byte;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_next;

endmodule

@@ rtl/core/ipv4fk_judge.sv @@
// ----------------------------------------------------------------------------
// ipv4fk_judge
// checks framing, length and version and forms the flow key result
// ----------------------------------------------------------------------------
module ipv4fk_judge
    import ipv4fk_pkg::*;
#(
    parameter int LW = 12
)
(
    input  logic [1:0]    link_type,
    input  logic [LW-1:0] frame_len,
    input  lane_key_t     eth_key,
    input  lane_key_t     ppp_key,
    input  lane_key_t     raw_key,
    output result_t       result
);

    lane_key_t     key;
    logic [LW-1:0] skip;
    logic          supported;
    logic          tag_ok;
    logic [LW-1:0] ip_len;
    logic [5:0]    ihl;
    logic [LW-1:0] l4_len;
    logic          is_tcp;
    logic          is_udp;
    logic [LW-1:0] need;

    always_comb
    begin
        key       = raw_key;
        skip      = LW'(RAW_SKIP);
        supported = 1'b1;
        tag_ok    = 1'b1;
        case (link_type)
            LT_ETH:
            begin
                key    = eth_key;
                skip   = LW'(ETH_SKIP);
                tag_ok = (eth_key.link_tag == ETHERTYPE_IPV4);
            end
            LT_PPP:
            begin
                key    = ppp_key;
                skip   = LW'(PPP_SKIP);
                tag_ok = (ppp_key.link_tag == PPP_PROTO_IPV4);
            end
            LT_RAW:
            begin
                key  = raw_key;
                skip = LW'(RAW_SKIP);
            end
            default:
            begin
                supported = 1'b0;
            end
        endcase

        ip_len = frame_len - skip;
        ihl    = {key.ver_ihl[3:0], 2'b00};
        l4_len = ip_len - LW'(ihl);
        is_tcp = (key.protocol == PROTO_TCP);
        is_udp = (key.protocol == PROTO_UDP);
        need   = is_tcp ? LW'(TCP_MIN_HDR) : LW'(UDP_MIN_HDR);

        result = '0;
        if (!supported)
            result.status = ST_NOT_IP;
        else if (frame_len <= skip)
            result.status = ST_BAD;
        else if (!tag_ok)
            result.status = ST_NOT_IP;
        else if ((ip_len < LW'(IP_MIN_HDR)) || (ip_len < LW'(ihl))
                 || (key.ver_ihl[7:4] != IP_VERSION_4))
            result.status = ST_BAD;
        else if ((is_tcp || is_udp) && (l4_len < need))
            result.status = ST_BAD;
        else
        begin
            result.status   = ST_OK;
            result.src_addr = key.src_addr;
            result.dst_addr = key.dst_addr;
            result.protocol = key.protocol;
            if (is_tcp || is_udp)
            begin
                result.src_port = key.src_port;
                result.dst_port = key.dst_port;
            end
        end
    end

endmodule

@@ rtl/core/ipv4_flow_key_extractor.sv @@
// ----------------------------------------------------------------------------
// ipv4_flow_key_extractor
// byte-wide frame parser that reports status and the ipv4 five-tuple
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  cfg       in         cfg_wr_en               cfg_wr_data (link type)
//  in        in         in_valid / in_ready     in_data (byte, last flag)
//  out       out        out_valid / out_ready   out_data (status, flow key)
//
//  one byte per cycle unless a last byte waits: input register, then header
//  capture and judge into the result register
//  a last byte waits in the input register only while a result is unread
//  all three framings are captured in parallel lanes; link type picks one
//  reset clears the byte counter, both valid flags and link type (ethernet)
// ----------------------------------------------------------------------------
`include "ipv4_flow_key_extractor_assert.svh"

module ipv4_flow_key_extractor
    import ipv4fk_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_data
);

    localparam int PW = $clog2(MAX_FRAME_BYTES);
    localparam int LW = PW + 1;
    localparam int CW = (PW > 7) ? PW : 7;

    logic [1:0]    link_type_reg;
    logic          a_valid_reg;
    in_item_t      a_item_reg;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic          over_reg;
    logic          over_next;
    logic          out_valid_reg;
    result_t       out_data_reg;

    logic          advance;
    logic          b_go;
    logic          cap_en;
    logic [CW-1:0] pos_cmp;
    logic [LW-1:0] frame_len;
    lane_key_t     eth_key;
    lane_key_t     ppp_key;
    lane_key_t     raw_key;
    result_t       judged;

    // only a last byte needs room in the result register
    assign advance  = !a_item_reg.last_byte || !out_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || advance;
    assign b_go     = a_valid_reg && advance;
    assign cap_en   = b_go && !over_reg;
    assign pos_cmp  = CW'(pos_reg);
    assign frame_len = over_reg ? LW'(MAX_FRAME_BYTES) : (LW'(pos_reg) + LW'(1));

    always_comb
    begin
        pos_next  = pos_reg;
        over_next = over_reg;
        if (b_go)
        begin
            if (a_item_reg.last_byte)
            begin
                pos_next  = '0;
                over_next = 1'b0;
            end
            else if (!over_reg)
            begin
                // oversize frame: counter parks on the last position
                if (pos_reg == PW'(MAX_FRAME_BYTES - 1))
                    over_next = 1'b1;
                else
                    pos_next = pos_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_type_reg <= LT_ETH;
            a_valid_reg   <= 1'b0;
            pos_reg       <= '0;
            over_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                link_type_reg <= cfg_wr_data;
            if (in_ready)
                a_valid_reg <= in_valid;
            pos_reg  <= pos_next;
            over_reg <= over_next;
            if (b_go && a_item_reg.last_byte)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            a_item_reg <= in_data;
        if (b_go && a_item_reg.last_byte)
            out_data_reg <= judged;
    end

    ipv4fk_lane #(
        .CW      (CW),
        .SKIP    (ETH_SKIP),
        .TAG_POS (ETH_TAG_POS)
    ) u_lane_eth (
        .clk       (clk),
        .cap_en    (cap_en),
        .pos       (pos_cmp),
        .data_byte (a_item_reg.data_byte),
        .key       (eth_key)
    );

    ipv4fk_lane #(
        .CW      (CW),
        .SKIP    (PPP_SKIP),
        .TAG_POS (PPP_TAG_POS)
    ) u_lane_ppp (
        .clk       (clk),
        .cap_en    (cap_en),
        .pos       (pos_cmp),
        .data_byte (a_item_reg.data_byte),
        .key       (ppp_key)
    );

    ipv4fk_lane #(
        .CW      (CW),
        .SKIP    (RAW_SKIP),
        .TAG_POS (RAW_SKIP)
    ) u_lane_raw (
        .clk       (clk),
        .cap_en    (cap_en),
        .pos       (pos_cmp),
        .data_byte (a_item_reg.data_byte),
        .key       (raw_key)
    );

    ipv4fk_judge #(
        .LW (LW)
    ) u_judge (
        .link_type (link_type_reg),
        .frame_len (frame_len),
        .eth_key   (eth_key),
        .ppp_key   (ppp_key),
        .raw_key   (raw_key),
        .result    (judged)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `IPV4FK_ASSERT_ALWAYS(a_pos_range, pos_reg <= PW'(MAX_FRAME_BYTES - 1), "byte counter out of range")
    `IPV4FK_ASSERT_ALWAYS(a_over_parked, !over_reg || (pos_reg == PW'(MAX_FRAME_BYTES - 1)), "oversize flag without parked counter")
    `IPV4FK_ASSERT_NEXT(a_last_gives_result, b_go && a_item_reg.last_byte, out_valid_reg && (pos_reg == '0) && !over_reg, "last byte did not produce a result")
    `IPV4FK_ASSERT_ALWAYS(a_fail_zero_key, !out_valid_reg || (out_data_reg.status == ST_OK) || ((out_data_reg.src_addr == '0) && (out_data_reg.dst_addr == '0) && (out_data_reg.protocol == '0) && (out_data_reg.src_port == '0) && (out_data_reg.dst_port == '0)), "failed result carries key fields")

endmodule
